/* rtl/tpw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tpw_pkg;

  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;

  localparam logic [1:0] OP_LOAD_CTRL = 2'd0;
  localparam logic [1:0] OP_LOAD_AFF  = 2'd1;
  localparam logic [1:0] OP_WARP      = 2'd2;

  localparam logic [1:0] MS_AFF = 2'd0;
  localparam logic [1:0] MS_SQ  = 2'd1;
  localparam logic [1:0] MS_WGT = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] wgt_x;
    logic signed [31:0] wgt_y;
    logic signed [31:0] wgt_z;
  } tpw_in_t;

  typedef struct packed {
    logic signed [31:0] warped_x;
    logic signed [31:0] warped_y;
    logic signed [31:0] warped_z;
  } tpw_out_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
  } tpw_ent_t;

  typedef struct packed {
    logic             ld_ctrl;
    logic             ld_aff;
    logic             cap_p;
    logic             mem_rd;
    logic [IDX_W-1:0] rd_idx;
    logic [1:0]       mul_sel;
    logic [1:0]       row;
    logic [1:0]       col;
    logic             acc_prod;
    logic             acc_bias;
    logic             clr_s;
    logic             acc_sq;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             out_load;
  } tpw_cmd_t;

endpackage
`default_nettype wire

/* rtl/tpw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module tpw_dp (
  input  wire logic            clk,
  input  wire tpw_pkg::tpw_in_t  in_data,
  input  wire tpw_pkg::tpw_cmd_t cmd,
  output tpw_pkg::tpw_out_t      out_data
);

  tpw_pkg::tpw_ent_t mem [tpw_pkg::MAX_POINTS];
  tpw_pkg::tpw_ent_t rd_r;
  logic [31:0] aff_r [12];
  logic [31:0] p_r [3];
  logic signed [63:0] acc_r [3];
  logic signed [tpw_pkg::PROD_W-1:0] prod_r;
  logic [63:0] s_r, v_r, res_r, bit_r;
  tpw_pkg::tpw_out_t out_r;

  logic [3:0]  aff_idx;
  logic [32:0] diff [3];
  logic [32:0] mag [3];
  logic [31:0] wsel;
  logic signed [tpw_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [63:0] sq;
  logic [64:0] s_sum;
  logic [63:0] trial;
  logic signed [63:0] prod_sh;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  always_comb begin
    diff[0] = {p_r[0][31], p_r[0]} - {rd_r.cx[31], rd_r.cx};
    diff[1] = {p_r[1][31], p_r[1]} - {rd_r.cy[31], rd_r.cy};
    diff[2] = {p_r[2][31], p_r[2]} - {rd_r.cz[31], rd_r.cz};
    for (int k = 0; k < 3; k++) begin
      mag[k] = diff[k][32] ? (33'd0 - diff[k]) : diff[k];
    end
    aff_idx = {1'b0, cmd.row, 1'b0} + {2'b00, cmd.row} + {2'b00, cmd.col};
    unique case (cmd.col)
      2'd0:    wsel = rd_r.wx;
      2'd1:    wsel = rd_r.wy;
      default: wsel = rd_r.wz;
    endcase
    unique case (cmd.mul_sel)
      tpw_pkg::MS_AFF: begin
        mul_a = $signed({{2{p_r[cmd.row][31]}}, p_r[cmd.row]});
        mul_b = $signed({{2{aff_r[aff_idx][31]}}, aff_r[aff_idx]});
      end
      tpw_pkg::MS_SQ: begin
        mul_a = $signed({1'b0, mag[cmd.col]});
        mul_b = $signed({1'b0, mag[cmd.col]});
      end
      default: begin
        mul_a = $signed({2'b00, res_r[31:0]});
        mul_b = $signed({{2{wsel[31]}}, wsel});
      end
    endcase
    // square of magnitude 2^32 lands on 2^64: clamp
    sq      = (|prod_r[tpw_pkg::PROD_W-1:64]) ? '1 : prod_r[63:0];
    s_sum   = {1'b0, s_r} + {1'b0, sq};
    trial   = res_r + bit_r;
    prod_sh = 64'(prod_r >>> tpw_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_ctrl) begin
      mem[tpw_pkg::IDX_W'(in_data.slot)] <= '{cx: in_data.pos_x, cy: in_data.pos_y,
        cz: in_data.pos_z, wx: in_data.wgt_x, wy: in_data.wgt_y, wz: in_data.wgt_z};
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[cmd.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_aff) begin
      aff_r[{1'b0, in_data.slot[1:0], 1'b0} + {2'b00, in_data.slot[1:0]}]        <= in_data.wgt_x;
      aff_r[{1'b0, in_data.slot[1:0], 1'b0} + {2'b00, in_data.slot[1:0]} + 4'd1] <= in_data.wgt_y;
      aff_r[{1'b0, in_data.slot[1:0], 1'b0} + {2'b00, in_data.slot[1:0]} + 4'd2] <= in_data.wgt_z;
    end
    prod_r <= mul_a * mul_b;
    if (cmd.cap_p) begin
      p_r[0] <= in_data.pos_x;
      p_r[1] <= in_data.pos_y;
      p_r[2] <= in_data.pos_z;
      for (int k = 0; k < 3; k++) acc_r[k] <= '0;
    end else if (cmd.acc_prod) begin
      acc_r[cmd.col] <= acc_r[cmd.col] + prod_sh;
    end else if (cmd.acc_bias) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= acc_r[k] + 64'($signed(aff_r[9 + k]));
      end
    end
    if (cmd.clr_s) begin
      s_r <= '0;
    end else if (cmd.acc_sq) begin
      s_r <= s_sum[64] ? '1 : s_sum[63:0];
    end
    if (cmd.sqrt_init) begin
      v_r   <= s_r;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.out_load) begin
      out_r.warped_x <= sat32(acc_r[0]);
      out_r.warped_y <= sat32(acc_r[1]);
      out_r.warped_z <= sat32(acc_r[2]);
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

/* rtl/tpw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module tpw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tpw_pkg::tpw_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output tpw_pkg::tpw_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_AFF_MUL = 4'd1;
  localparam logic [3:0] S_AFF_ACC = 4'd2;
  localparam logic [3:0] S_BIAS    = 4'd3;
  localparam logic [3:0] S_RD      = 4'd4;
  localparam logic [3:0] S_SQ_MUL  = 4'd5;
  localparam logic [3:0] S_SQ_ACC  = 4'd6;
  localparam logic [3:0] S_SQI     = 4'd7;
  localparam logic [3:0] S_SQRT    = 4'd8;
  localparam logic [3:0] S_W_MUL   = 4'd9;
  localparam logic [3:0] S_W_ACC   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;
  logic [tpw_pkg::CNT_W-1:0] j_r, j_nxt, n_pts;
  logic [4:0] it_r, it_nxt;
  logic [8:0] active_r;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign n_pts    = (32'(active_r) < 32'(tpw_pkg::MAX_POINTS)) ?
                    tpw_pkg::CNT_W'(active_r) : tpw_pkg::CNT_W'(tpw_pkg::MAX_POINTS);
  assign out_valid  = out_valid_r;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {23'd0, active_r} : 32'd0;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    j_nxt         = j_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.rd_idx    = j_r[tpw_pkg::IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.op)
            tpw_pkg::OP_LOAD_CTRL:
              cmd.ld_ctrl = (32'(in_data.slot) < 32'(tpw_pkg::MAX_POINTS));
            tpw_pkg::OP_LOAD_AFF:
              cmd.ld_aff = (in_data.slot <= 8'd3);
            tpw_pkg::OP_WARP: begin
              cmd.cap_p = 1'b1;
              row_nxt   = 2'd0;
              col_nxt   = 2'd0;
              state_nxt = S_AFF_MUL;
            end
            default: ;
          endcase
        end
      end
      S_AFF_MUL: begin
        cmd.mul_sel = tpw_pkg::MS_AFF;
        state_nxt   = S_AFF_ACC;
      end
      S_AFF_ACC: begin
        cmd.acc_prod = 1'b1;
        state_nxt    = S_AFF_MUL;
        if (col_r == 2'd2) begin
          col_nxt = 2'd0;
          if (row_r == 2'd2) state_nxt = S_BIAS;
          else row_nxt = row_r + 2'd1;
        end else begin
          col_nxt = col_r + 2'd1;
        end
      end
      S_BIAS: begin
        cmd.acc_bias = 1'b1;
        j_nxt        = '0;
        state_nxt    = (n_pts == '0) ? S_DONE : S_RD;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.clr_s  = 1'b1;
        col_nxt    = 2'd0;
        state_nxt  = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.mul_sel = tpw_pkg::MS_SQ;
        state_nxt   = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.acc_sq = 1'b1;
        if (col_r == 2'd2) begin
          col_nxt   = 2'd0;
          state_nxt = S_SQI;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        it_nxt        = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        it_nxt        = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = S_W_MUL;
      end
      S_W_MUL: begin
        cmd.mul_sel = tpw_pkg::MS_WGT;
        state_nxt   = S_W_ACC;
      end
      S_W_ACC: begin
        cmd.acc_prod = 1'b1;
        if (col_r == 2'd2) begin
          col_nxt   = 2'd0;
          j_nxt     = j_r + 1'b1;
          state_nxt = (j_r + 1'b1 == n_pts) ? S_DONE : S_RD;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = S_W_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= 9'd1;
      row_r       <= '0;
      col_r       <= '0;
      j_r         <= '0;
      it_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      j_r         <= j_nxt;
      it_r        <= it_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0) begin
        active_r <= cfg_pwdata[8:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/tps_point_warp_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Ports                          | Transaction
// in_      | input     | in_valid, in_stall, in_data    | one load or warp item
// out_     | output    | out_valid, out_stall, out_data | one warped point
// cfg_     | input     | APB-style, paddr 3 bits        | active_points at 0x0
//
// Loads (control point, affine row) complete when accepted. A warp stalls the
// input while it works through N active points on the one shared 34x34
// multiplier and the bit-serial square root (32 steps per control point).
// Reset is synchronous; it clears control state and sets active_points to 1.
// A finished result waits in the output register; loads are still taken
// while it is stalled, and the next warp holds in its last step until the
// output register frees up.
module tps_point_warp_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tpw_pkg::tpw_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tpw_pkg::tpw_out_t      out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  tpw_pkg::tpw_cmd_t cmd;

  // register port never waits
  assign cfg_pready = 1'b1;

  // sequence the warp: affine terms, then per control point the distance,
  // the square root and the weighted sums
  tpw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cmd         (cmd)
  );

  // hold the point tables, the multiplier, the accumulators and the result
  tpw_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

/* rtl/tpw_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
module tpw_chk (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire tpw_pkg::tpw_in_t in_data,
  input wire logic             out_valid,
  input wire logic             out_stall
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_warp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == tpw_pkg::OP_WARP) |=> in_stall)
    else $error("input taken while a warp is in progress");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op != tpw_pkg::OP_WARP) |=> !in_stall)
    else $error("load did not complete in one cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind tps_point_warp_unit tpw_chk u_tpw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  // APB byte address of the active_points register
  localparam logic [2:0] REG_ACTIVE_POINTS = 3'd0;
  // op code that the block drops on the floor
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // generous bound: slowest legal run is far below this
  localparam int CYCLE_LIMIT = 3000000;
  // settle time after the last result before touching config or ending
  localparam int SETTLE_CYCLES = 32;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tpw_pkg::tpw_in_t  in_data;
  logic        out_valid;
  logic        out_stall;
  tpw_pkg::tpw_out_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tps_point_warp_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow of the block's tables and register, updated on each accepted
  // transaction.
  logic signed [31:0] ctl_x [tpw_pkg::MAX_POINTS];
  logic signed [31:0] ctl_y [tpw_pkg::MAX_POINTS];
  logic signed [31:0] ctl_z [tpw_pkg::MAX_POINTS];
  logic signed [31:0] ctl_wx [tpw_pkg::MAX_POINTS];
  logic signed [31:0] ctl_wy [tpw_pkg::MAX_POINTS];
  logic signed [31:0] ctl_wz [tpw_pkg::MAX_POINTS];
  logic signed [31:0] aff_m [12];
  logic [8:0]         active_cnt;

  tpw_pkg::tpw_out_t warp_expect[$];
  int       n_err;
  int       n_items;
  int       n_warps;
  int       gap_pct;
  int       stall_pct;
  int       cyc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up if the block hangs.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cyc, warp_expect.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side stall, driven at the falling edge.
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Floor of the integer square root of a 64-bit value.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned diff_sq(input longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : d;
    if (m > 64'hFFFF_FFFF) return 64'hFFFF_FFFF_FFFF_FFFF;
    return m * m;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Affine part plus the radial sum over the active control points.
  function automatic tpw_pkg::tpw_out_t warp_point(input tpw_pkg::tpw_in_t it);
    longint          pc [3];
    longint          acc [3];
    logic [64:0]     dsum;
    longint          rad;
    int              n;
    tpw_pkg::tpw_out_t r;
    pc[0] = it.pos_x;
    pc[1] = it.pos_y;
    pc[2] = it.pos_z;
    for (int k = 0; k < 3; k++) begin
      acc[k] = ((pc[0] * longint'(aff_m[k])) >>> tpw_pkg::FRAC_BITS)
             + ((pc[1] * longint'(aff_m[3 + k])) >>> tpw_pkg::FRAC_BITS)
             + ((pc[2] * longint'(aff_m[6 + k])) >>> tpw_pkg::FRAC_BITS)
             + longint'(aff_m[9 + k]);
    end
    n = (active_cnt < tpw_pkg::MAX_POINTS) ? active_cnt : tpw_pkg::MAX_POINTS;
    for (int j = 0; j < n; j++) begin
      dsum = {1'b0, diff_sq(pc[0] - longint'(ctl_x[j]))};
      dsum = dsum + {1'b0, diff_sq(pc[1] - longint'(ctl_y[j]))};
      if (dsum[64]) dsum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      dsum = dsum + {1'b0, diff_sq(pc[2] - longint'(ctl_z[j]))};
      if (dsum[64]) dsum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      rad = root_floor(dsum[63:0]);
      acc[0] += (rad * longint'(ctl_wx[j])) >>> tpw_pkg::FRAC_BITS;
      acc[1] += (rad * longint'(ctl_wy[j])) >>> tpw_pkg::FRAC_BITS;
      acc[2] += (rad * longint'(ctl_wz[j])) >>> tpw_pkg::FRAC_BITS;
    end
    r.warped_x = clamp32(acc[0]);
    r.warped_y = clamp32(acc[1]);
    r.warped_z = clamp32(acc[2]);
    return r;
  endfunction

  // Apply one accepted transaction to the shadow state.
  function automatic void apply_item(input tpw_pkg::tpw_in_t it);
    case (it.op)
      tpw_pkg::OP_LOAD_CTRL: begin
        if (it.slot < tpw_pkg::MAX_POINTS) begin
          ctl_x[it.slot] = it.pos_x;
          ctl_y[it.slot] = it.pos_y;
          ctl_z[it.slot] = it.pos_z;
          ctl_wx[it.slot] = it.wgt_x;
          ctl_wy[it.slot] = it.wgt_y;
          ctl_wz[it.slot] = it.wgt_z;
        end
      end
      tpw_pkg::OP_LOAD_AFF: begin
        if (it.slot <= 3) begin
          aff_m[3 * it.slot]     = it.wgt_x;
          aff_m[3 * it.slot + 1] = it.wgt_y;
          aff_m[3 * it.slot + 2] = it.wgt_z;
        end
      end
      tpw_pkg::OP_WARP: begin
        warp_expect.push_back(warp_point(it));
        n_warps++;
      end
      default: ;
    endcase
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (warp_expect.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                 out_data.warped_x, out_data.warped_y, out_data.warped_z);
        n_err++;
      end else begin
        if (out_data.warped_x !== warp_expect[0].warped_x) begin
          $display("%0t: warped_x expected %h actual %h", $time,
                   warp_expect[0].warped_x, out_data.warped_x);
          n_err++;
        end
        if (out_data.warped_y !== warp_expect[0].warped_y) begin
          $display("%0t: warped_y expected %h actual %h", $time,
                   warp_expect[0].warped_y, out_data.warped_y);
          n_err++;
        end
        if (out_data.warped_z !== warp_expect[0].warped_z) begin
          $display("%0t: warped_z expected %h actual %h", $time,
                   warp_expect[0].warped_z, out_data.warped_z);
          n_err++;
        end
        void'(warp_expect.pop_front());
      end
    end
  end

  // Send one transaction; insert random sender gaps first, hold until taken.
  task automatic send_item(input tpw_pkg::tpw_in_t it);
    @(negedge clk);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    apply_item(it);
    n_items++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    wait (warp_expect.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input logic [8:0] v);
    drain;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = REG_ACTIVE_POINTS;
    cfg_pwdata = {23'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    active_cnt = v;
  endtask

  // Mix of extremes, small coordinates and full-range words.
  function automatic logic [31:0] pick_word;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic tpw_pkg::tpw_in_t make_item(input logic [1:0] op,
                                                 input logic [7:0] slot);
    tpw_pkg::tpw_in_t it;
    it.op = op;
    it.slot = slot;
    it.pos_x = pick_word();
    it.pos_y = pick_word();
    it.pos_z = pick_word();
    it.wgt_x = pick_word();
    it.wgt_y = pick_word();
    it.wgt_z = pick_word();
    return it;
  endfunction

  // Fill every control slot and affine row so no warp reads an unwritten entry.
  task automatic test_preload;
    for (int s = 0; s < tpw_pkg::MAX_POINTS; s++)
      send_item(make_item(tpw_pkg::OP_LOAD_CTRL, 8'(s)));
    for (int r = 0; r < 4; r++) send_item(make_item(tpw_pkg::OP_LOAD_AFF, 8'(r)));
  endtask

  // Directed corners: identity affine, extreme points, zero distance,
  // ignored ops and out-of-range affine rows.
  task automatic test_directed;
    tpw_pkg::tpw_in_t it;
    it = '{op: tpw_pkg::OP_LOAD_AFF, slot: 8'd0, pos_x: 32'h7FFF_FFFF,
           pos_y: 32'h8000_0000, pos_z: 0, wgt_x: 32'h0001_0000, wgt_y: 0, wgt_z: 0};
    send_item(it);
    it.slot = 8'd1; it.wgt_x = 0; it.wgt_y = 32'h0001_0000;
    send_item(it);
    it.slot = 8'd2; it.wgt_y = 0; it.wgt_z = 32'h0001_0000;
    send_item(it);
    it.slot = 8'd3; it.wgt_x = 32'h7FFF_FFFF; it.wgt_y = 32'h8000_0000; it.wgt_z = 0;
    send_item(it);
    // rows above 3 must leave the matrix alone
    it.slot = 8'd4; it.wgt_x = $urandom; it.wgt_y = $urandom; it.wgt_z = $urandom;
    send_item(it);
    it.slot = 8'hFF;
    send_item(it);
    // control point 0 at a corner, heavy weights
    it = '{op: tpw_pkg::OP_LOAD_CTRL, slot: 8'd0, pos_x: 32'h8000_0000,
           pos_y: 32'h8000_0000, pos_z: 32'h8000_0000, wgt_x: 32'h7FFF_FFFF,
           wgt_y: 32'h8000_0000, wgt_z: 32'h0001_0000};
    send_item(it);
    // query right on the control point: zero distance
    it.op = tpw_pkg::OP_WARP;
    send_item(it);
    // opposite corner: largest distance, saturating sums
    it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h7FFF_FFFF; it.pos_z = 32'h7FFF_FFFF;
    send_item(it);
    it.pos_x = 0; it.pos_y = 0; it.pos_z = 0;
    send_item(it);
    // op 3 is dropped without a result
    it.op = OP_UNUSED;
    send_item(it);
    send_item(make_item(OP_UNUSED, 8'hA5));
    for (int i = 0; i < 4; i++) send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
    send_item(make_item(tpw_pkg::OP_LOAD_CTRL, 8'hFF));
    send_item(make_item(tpw_pkg::OP_WARP, 8'h00));
  endtask

  // Active count extremes: empty sum, full table, and beyond the table size.
  task automatic test_count_extremes;
    write_active(9'd0);
    repeat (3) send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
    write_active(9'd256);
    repeat (2) send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
    write_active(9'd511);
    repeat (2) send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
    write_active(9'd257);
    send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
  endtask

  // Random loads and warps; small active counts keep warps short.
  task automatic test_random(input int count, input logic [8:0] act);
    int sel;
    write_active(act);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        send_item(make_item(tpw_pkg::OP_WARP, 8'($urandom)));
      else if (sel < 80)
        send_item(make_item(tpw_pkg::OP_LOAD_CTRL, 8'($urandom_range(0, 15))));
      else if (sel < 88)
        send_item(make_item(tpw_pkg::OP_LOAD_CTRL, 8'($urandom)));
      else if (sel < 96)
        send_item(make_item(tpw_pkg::OP_LOAD_AFF, 8'($urandom_range(0, 7))));
      else
        send_item(make_item(OP_UNUSED, 8'($urandom)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    active_cnt = 9'd1;
    n_err = 0;
    n_items = 0;
    n_warps = 0;
    gap_pct = 0;
    stall_pct = 0;
    cyc = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_preload;
    test_directed;
    // pause the sender until every result is back
    drain;
    test_count_extremes;

    // idle phases: none, sender gaps, receiver stalls, both lightly
    gap_pct = 0;  stall_pct = 0;  test_random(200, 9'($urandom_range(1, 8)));
    gap_pct = 70; stall_pct = 0;  test_random(200, 9'($urandom_range(1, 8)));
    gap_pct = 0;  stall_pct = 70; test_random(200, 9'($urandom_range(1, 16)));
    gap_pct = 11; stall_pct = 11; test_random(200, 9'($urandom_range(1, 4)));
    gap_pct = 11; stall_pct = 11; test_random(10, 9'd256);
    gap_pct = 0;  stall_pct = 0;  test_random(60, 9'd1);

    drain;
    $display("%0d transactions sent, %0d warps checked, active counts 0 to 511,",
             n_items, n_warps);
    $display("with sender gaps and receiver stalls in separate and combined phases");
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_err);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tpw_pkg.sv
rtl/tpw_dp.sv
rtl/tpw_ctrl.sv
rtl/tps_point_warp_unit.sv
rtl/tpw_chk.sv
verif/tb_top.sv
